### design/rvsc_pkg.sv
// Shared types and constants for the small RISC-V style multicycle core.
// Used by the memory, the register file, the word index unit and the top level.
package rvsc_pkg;

    localparam int MEM_WORDS_DEF = 65536;
    localparam int XLEN = 32;
    localparam int REG_ADDR_W = 5;
    localparam int REG_COUNT = 32;
    localparam int WA_W = 16;
    localparam int VAL_W = 30;
    localparam logic [REG_ADDR_W-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_ADDR_W-1:0] REG_RET = 5'd10;

    typedef struct packed {
        logic                  we;
        logic [REG_ADDR_W-1:0] addr;
        logic [XLEN-1:0]       data;
    } t_rf_wr;

endpackage

### design/rvsc_mem.sv
// Main word memory with one synchronous read/write port and registered read data.
// Depends on rvsc_pkg for the data width.
module rvsc_mem #(
    parameter int MEM_WORDS = rvsc_pkg::MEM_WORDS_DEF,
    parameter int AW = $clog2(MEM_WORDS)
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [rvsc_pkg::XLEN-1:0]  i_wdata,
    output logic [rvsc_pkg::XLEN-1:0]  o_rdata
);

    logic [rvsc_pkg::XLEN-1:0] r_mem [MEM_WORDS];
    logic [rvsc_pkg::XLEN-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/rvsc_regfile.sv
// Register file with two registered read ports and one write port.
// Entries read as zero until written; entry zero is never written. Uses rvsc_pkg.
module rvsc_regfile (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_re,
    input  logic [rvsc_pkg::REG_ADDR_W-1:0]  i_ra1,
    input  logic [rvsc_pkg::REG_ADDR_W-1:0]  i_ra2,
    input  rvsc_pkg::t_rf_wr                 i_wr,
    output logic [rvsc_pkg::XLEN-1:0]        o_rd1,
    output logic [rvsc_pkg::XLEN-1:0]        o_rd2
);

    logic [rvsc_pkg::XLEN-1:0]      r_mem [rvsc_pkg::REG_COUNT];
    logic [rvsc_pkg::REG_COUNT-1:0] r_valid;
    logic [rvsc_pkg::XLEN-1:0]      r_d1;
    logic [rvsc_pkg::XLEN-1:0]      r_d2;
    logic                           r_v1;
    logic                           r_v2;
    logic                           w_we;

    assign w_we = i_wr.we && (i_wr.addr != rvsc_pkg::REG_ZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_re) begin
            r_d1 <= r_mem[i_ra1];
            r_d2 <= r_mem[i_ra2];
            r_v1 <= r_valid[i_ra1];
            r_v2 <= r_valid[i_ra2];
        end
    end

    assign o_rd1 = r_v1 ? r_d1 : '0;
    assign o_rd2 = r_v2 ? r_d2 : '0;

endmodule

### design/rvsc_widx.sv
// Reduces a 30-bit word number modulo the memory depth.
// A power-of-two depth is a mask; any other depth multiplies by a constant reciprocal and
// corrects once. Uses rvsc_pkg.
module rvsc_widx #(
    parameter int MEM_WORDS = rvsc_pkg::MEM_WORDS_DEF,
    parameter int AW = $clog2(MEM_WORDS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rvsc_pkg::VAL_W-1:0] i_value,
    output logic                       o_done,
    output logic [AW-1:0]              o_index
);

    localparam bit IS_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            assign o_done  = i_start;
            assign o_index = i_value[AW-1:0];
        end else begin : g_recip
            localparam int RW = rvsc_pkg::VAL_W + 1 - AW;
            localparam int PW = rvsc_pkg::VAL_W + RW;
            localparam int QW = rvsc_pkg::VAL_W + 1;
            localparam logic [AW:0] MOD = (AW + 1)'(MEM_WORDS);
            localparam logic [RW-1:0] RECIP =
                RW'((64'd1 << rvsc_pkg::VAL_W) / 64'(MEM_WORDS));
            localparam logic [1:0] STEP_LAST = 2'd2;

            logic                       r_busy;
            logic [1:0]                 r_step;
            logic [rvsc_pkg::VAL_W-1:0] r_val;
            logic [RW-1:0]              r_quo;
            logic [rvsc_pkg::VAL_W-1:0] r_qm;
            logic [PW-1:0]              w_prod;
            logic [QW-1:0]              w_qm;
            logic [rvsc_pkg::VAL_W-1:0] w_diff;
            logic [AW:0]                w_rem;
            logic [AW:0]                w_fix;

            // The estimated quotient is exact or one short, so one subtract corrects it.
            assign w_prod = r_val * RECIP;
            assign w_qm   = QW'(r_quo) * QW'(MOD);
            assign w_diff = r_val - r_qm;
            assign w_rem  = w_diff[AW:0];
            assign w_fix  = (w_rem >= MOD) ? (w_rem - MOD) : w_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else if (!r_busy) begin
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_step <= '0;
                    end
                end else if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!r_busy) begin
                    r_val <= i_value;
                end
                r_quo <= w_prod[PW-1:rvsc_pkg::VAL_W];
                r_qm  <= w_qm[rvsc_pkg::VAL_W-1:0];
            end

            assign o_done  = r_busy && (r_step == STEP_LAST);
            assign o_index = w_fix[AW-1:0];
        end
    endgenerate

endmodule

### design/rv32_subset_multicycle_core.sv
// Multicycle core: ALU, LUI, JALR, load and store instructions step from acceptance to
// result through fetch, decode, execute and result load around the single memory port;
// memory word writes and reads through address reduction and access. A depth that is not
// a power of two makes each address reduction wait for the reciprocal unit in rvsc_widx.
// The next transaction is accepted the cycle after the result is loaded.
// Synchronous active-low reset clears pc, flags, registers and control; memory is not cleared.
module rv32_subset_multicycle_core #(
    parameter int MEM_WORDS = rvsc_pkg::MEM_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_operation,
    input  logic [rvsc_pkg::WA_W-1:0]  i_word_address,
    input  logic [rvsc_pkg::XLEN-1:0]  i_write_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rvsc_pkg::XLEN-1:0]  o_program_counter,
    output logic [rvsc_pkg::XLEN-1:0]  o_read_data,
    output logic                       o_halted,
    output logic                       o_fault,
    output logic [rvsc_pkg::XLEN-1:0]  o_result_register
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int XL = rvsc_pkg::XLEN;
    localparam int ZW = rvsc_pkg::VAL_W - rvsc_pkg::WA_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_IDX     = 3'd1;
    localparam logic [2:0] S_RDWAIT  = 3'd2;
    localparam logic [2:0] S_DECODE  = 3'd3;
    localparam logic [2:0] S_EXEC    = 3'd4;
    localparam logic [2:0] S_EIDX    = 3'd5;
    localparam logic [2:0] S_MEMWAIT = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    localparam logic [1:0] OPR_WRITE = 2'd0;
    localparam logic [1:0] OPR_EXEC  = 2'd1;
    localparam logic [1:0] OPR_READ  = 2'd2;

    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_ADDI  = 7'h13;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_ADD   = 7'h33;
    localparam logic [6:0] OPC_LUI   = 7'h37;
    localparam logic [6:0] OPC_JALR  = 7'h67;
    localparam logic [6:0] OPC_HALT  = 7'h7F;

    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [XL-1:0]             r_pc, n_pc;
    logic                      r_halt, n_halt;
    logic                      r_fault, n_fault;
    logic [XL-1:0]             r_x10, n_x10;
    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_op, n_op;
    logic [rvsc_pkg::WA_W-1:0] r_wa, n_wa;
    logic [XL-1:0]             r_wd, n_wd;
    logic [XL-1:0]             r_ins, n_ins;
    logic [XL-1:0]             r_ea, n_ea;
    logic [AW-1:0]             r_idx, n_idx;
    logic [XL-1:0]             r_rdata, n_rdata;
    logic [XL-1:0]             r_o_pc;
    logic [XL-1:0]             r_o_rdata;
    logic                      r_o_halt;
    logic                      r_o_fault;
    logic [XL-1:0]             r_o_x10;

    logic                         w_accept;
    logic                         w_out_free;
    logic [1:0]                   w_cur_op;
    logic                         w_idx_start;
    logic [rvsc_pkg::VAL_W-1:0]   w_idx_value;
    logic                         w_idx_done;
    logic [AW-1:0]                w_idx;
    logic                         w_mem_en;
    logic                         w_mem_we;
    logic [AW-1:0]                w_mem_addr;
    logic [XL-1:0]                w_mem_wdata;
    logic [XL-1:0]                w_mem_rdata;
    logic                         w_rf_re;
    rvsc_pkg::t_rf_wr             w_rf_wr;
    logic [XL-1:0]                w_a;
    logic [XL-1:0]                w_b;
    logic [6:0]                   w_opc;
    logic [2:0]                   w_f3;
    logic [rvsc_pkg::REG_ADDR_W-1:0] w_rd;
    logic [XL-1:0]                w_iimm;
    logic [XL-1:0]                w_simm;
    logic [XL-1:0]                w_next_pc;
    logic [7:0]                   w_byte;
    logic [XL-1:0]                w_merged;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cur_op   = (r_state == S_IDLE) ? i_operation : r_op;

    assign w_opc     = r_ins[6:0];
    assign w_rd      = r_ins[11:7];
    assign w_f3      = r_ins[14:12];
    assign w_iimm    = {{20{r_ins[31]}}, r_ins[31:20]};
    assign w_simm    = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign w_next_pc = r_pc + 32'd4;

    always_comb begin
        case (r_ea[1:0])
            2'd0:    w_byte = w_mem_rdata[7:0];
            2'd1:    w_byte = w_mem_rdata[15:8];
            2'd2:    w_byte = w_mem_rdata[23:16];
            default: w_byte = w_mem_rdata[31:24];
        endcase
    end

    always_comb begin
        w_merged = w_mem_rdata;
        case (r_ea[1:0])
            2'd0:    w_merged[7:0]   = w_b[7:0];
            2'd1:    w_merged[15:8]  = w_b[7:0];
            2'd2:    w_merged[23:16] = w_b[7:0];
            default: w_merged[31:24] = w_b[7:0];
        endcase
    end

    always_comb begin
        w_idx_start = 1'b0;
        w_idx_value = '0;
        unique case (r_state)
            S_IDLE: begin
                w_idx_start = w_accept && ((i_operation == OPR_WRITE) ||
                              (i_operation == OPR_READ) ||
                              ((i_operation == OPR_EXEC) && !r_halt));
                w_idx_value = (i_operation == OPR_EXEC) ? r_pc[31:2] :
                              {{ZW{1'b0}}, i_word_address};
            end
            S_IDX: begin
                w_idx_start = 1'b1;
                w_idx_value = (r_op == OPR_EXEC) ? r_pc[31:2] : {{ZW{1'b0}}, r_wa};
            end
            S_EIDX: begin
                w_idx_start = 1'b1;
                w_idx_value = r_ea[31:2];
            end
            default: begin
                w_idx_start = 1'b0;
                w_idx_value = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_fault     = r_fault;
        n_op        = r_op;
        n_wa        = r_wa;
        n_wd        = r_wd;
        n_ins       = r_ins;
        n_ea        = r_ea;
        n_idx       = r_idx;
        n_rdata     = r_rdata;
        w_mem_en    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = w_idx;
        w_mem_wdata = (r_state == S_IDLE) ? i_write_data : r_wd;
        w_rf_re     = 1'b0;
        w_rf_wr     = '0;

        unique case (r_state)
            S_IDLE, S_IDX: begin
                if (r_state == S_IDLE && w_accept) begin
                    n_op    = i_operation;
                    n_wa    = i_word_address;
                    n_wd    = i_write_data;
                    n_rdata = '0;
                    n_state = w_idx_start ? S_IDX : S_DONE;
                end
                if (w_idx_start && w_idx_done) begin
                    w_mem_en = 1'b1;
                    unique case (w_cur_op)
                        OPR_WRITE: begin
                            w_mem_we = 1'b1;
                            n_state  = S_DONE;
                        end
                        OPR_READ: n_state = S_RDWAIT;
                        default:  n_state = S_DECODE;
                    endcase
                end
            end
            S_RDWAIT: begin
                n_rdata = w_mem_rdata;
                n_state = S_DONE;
            end
            S_DECODE: begin
                n_ins   = w_mem_rdata;
                w_rf_re = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (w_opc)
                    OPC_HALT: n_halt = 1'b1;
                    OPC_JALR: begin
                        if (w_f3 == F3_BYTE) begin
                            w_rf_wr = '{we: 1'b1, addr: w_rd, data: w_next_pc};
                            n_pc    = (w_a + w_iimm) & 32'hFFFF_FFFC;
                        end else begin
                            n_fault = 1'b1;
                            n_halt  = 1'b1;
                        end
                    end
                    OPC_ADDI: begin
                        if (w_f3 == F3_BYTE) begin
                            w_rf_wr = '{we: 1'b1, addr: w_rd, data: w_a + w_iimm};
                            n_pc    = w_next_pc;
                        end else begin
                            n_fault = 1'b1;
                            n_halt  = 1'b1;
                        end
                    end
                    OPC_ADD: begin
                        if (w_f3 == F3_BYTE) begin
                            w_rf_wr = '{we: 1'b1, addr: w_rd, data: w_a + w_b};
                            n_pc    = w_next_pc;
                        end else begin
                            n_fault = 1'b1;
                            n_halt  = 1'b1;
                        end
                    end
                    OPC_LUI: begin
                        w_rf_wr = '{we: 1'b1, addr: w_rd, data: r_ins & 32'hFFFF_F000};
                        n_pc    = w_next_pc;
                    end
                    OPC_LOAD: begin
                        if (w_f3 == F3_WORD || w_f3 == F3_BYTEU) begin
                            n_ea    = w_a + w_iimm;
                            n_state = S_EIDX;
                        end else begin
                            n_fault = 1'b1;
                            n_halt  = 1'b1;
                        end
                    end
                    OPC_STORE: begin
                        if (w_f3 == F3_WORD || w_f3 == F3_BYTE) begin
                            n_ea    = w_a + w_simm;
                            n_state = S_EIDX;
                        end else begin
                            n_fault = 1'b1;
                            n_halt  = 1'b1;
                        end
                    end
                    default: begin
                        n_fault = 1'b1;
                        n_halt  = 1'b1;
                    end
                endcase
            end
            S_EIDX: begin
                if (w_idx_done) begin
                    n_idx    = w_idx;
                    w_mem_en = 1'b1;
                    if (w_opc == OPC_STORE && w_f3 == F3_WORD) begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = w_b;
                        n_pc        = w_next_pc;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_MEMWAIT;
                    end
                end
            end
            S_MEMWAIT: begin
                w_mem_addr = r_idx;
                n_pc       = w_next_pc;
                n_state    = S_DONE;
                if (w_opc == OPC_STORE) begin
                    w_mem_en    = 1'b1;
                    w_mem_we    = 1'b1;
                    w_mem_wdata = w_merged;
                end else if (w_f3 == F3_WORD) begin
                    w_rf_wr = '{we: 1'b1, addr: w_rd, data: w_mem_rdata};
                end else begin
                    w_rf_wr = '{we: 1'b1, addr: w_rd, data: {24'd0, w_byte}};
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_x10 = (w_rf_wr.we && w_rf_wr.addr == rvsc_pkg::REG_RET) ? w_rf_wr.data : r_x10;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_fault     <= 1'b0;
            r_x10       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_fault     <= n_fault;
            r_x10       <= n_x10;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_wa    <= n_wa;
        r_wd    <= n_wd;
        r_ins   <= n_ins;
        r_ea    <= n_ea;
        r_idx   <= n_idx;
        r_rdata <= n_rdata;
        if (r_state == S_DONE && w_out_free) begin
            r_o_pc    <= r_pc;
            r_o_rdata <= r_rdata;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
            r_o_x10   <= r_x10;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_o_pc;
    assign o_read_data       = r_o_rdata;
    assign o_halted          = r_o_halt;
    assign o_fault           = r_o_fault;
    assign o_result_register = r_o_x10;

    rvsc_widx #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_widx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_idx_start),
        .i_value (w_idx_value),
        .o_done  (w_idx_done),
        .o_index (w_idx)
    );

    rvsc_mem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    rvsc_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_rf_re),
        .i_ra1   (w_mem_rdata[19:15]),
        .i_ra2   (w_mem_rdata[24:20]),
        .i_wr    (w_rf_wr),
        .o_rd1   (w_a),
        .o_rd2   (w_b)
    );

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> r_halt)
        else $error("Fault flag set without halt flag.");

    a_halt_freezes_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_pc))
        else $error("Program counter moved while halted.");

    a_rf_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rf_wr.we |-> (r_state == S_EXEC || r_state == S_MEMWAIT))
        else $error("Register file written outside execute or load completion.");

    a_mem_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_en && w_mem_we) |-> (r_state != S_DECODE && r_state != S_EXEC &&
                                    r_state != S_RDWAIT && r_state != S_DONE))
        else $error("Memory written in a state that does not store.");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rv32_subset_multicycle_core: program loading, execution,
// memory reads, halt and fault, with random idling on both handshakes.
// Depends on rvsc_pkg and the core RTL only; the scoreboard class predicts each result.
module testbench;
    import rvsc_pkg::*;

    localparam int ITEMS_TARGET = 500;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        OP_WRITE_WORD = 2'd0,
        OP_EXECUTE    = 2'd1,
        OP_READ_WORD  = 2'd2,
        OP_UNUSED     = 2'd3
    } core_op_e;

    localparam logic [6:0] OPC_HALT  = 7'h7F;
    localparam logic [6:0] OPC_JALR  = 7'h67;
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_OPIMM = 7'h13;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_LUI   = 7'h37;
    localparam logic [6:0] OPC_OP    = 7'h33;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SW   = 3'd2;

    typedef struct packed {
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] rdata;
        logic            halted;
        logic            fault;
        logic [XLEN-1:0] ret_value;
    } core_status_t;

    class core_scoreboard;
        logic [XLEN-1:0] mem_words [int];
        int              written_list [$];
        logic [XLEN-1:0] regs [REG_COUNT];
        logic [XLEN-1:0] pc;
        logic            halted;
        logic            faulted;
        core_status_t    expected_status [$];
        int              errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            halted = 1'b0;
            faulted = 1'b0;
            errors = 0;
        endfunction

        function int word_of(logic [XLEN-1:0] byte_addr);
            return int'((byte_addr >> 2) % MEM_WORDS_DEF);
        endfunction

        function void store_word(int idx, logic [XLEN-1:0] value);
            if (!mem_words.exists(idx)) written_list.push_back(idx);
            mem_words[idx] = value;
        endfunction

        function logic [XLEN-1:0] load_word(int idx);
            return mem_words.exists(idx) ? mem_words[idx] : '0;
        endfunction

        function void write_reg(logic [REG_ADDR_W-1:0] rd, logic [XLEN-1:0] value);
            if (rd != REG_ZERO) regs[rd] = value;
        endfunction

        function void advance_core();
            logic [XLEN-1:0] ins, a, b, iimm, simm, nxt, ea, w;
            logic [6:0]      opc;
            logic [2:0]      f3;
            logic [4:0]      rd;
            ins = load_word(word_of(pc));
            opc = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            a = regs[ins[19:15]];
            b = regs[ins[24:20]];
            iimm = {{20{ins[31]}}, ins[31:20]};
            simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            nxt = pc + 32'd4;
            if (opc == OPC_HALT) begin
                halted = 1'b1;
                return;
            end
            if (opc == OPC_JALR && f3 == F3_JALR) begin
                write_reg(rd, nxt);
                pc = (a + iimm) & ~32'd3;
                return;
            end
            if (opc == OPC_LOAD && (f3 == F3_LW || f3 == F3_LBU)) begin
                ea = a + iimm;
                w = load_word(word_of(ea));
                if (f3 == F3_LW) write_reg(rd, w);
                else write_reg(rd, {24'd0, w[ea[1:0]*8 +: 8]});
            end else if (opc == OPC_OPIMM && f3 == F3_ADD) begin
                write_reg(rd, a + iimm);
            end else if (opc == OPC_STORE && (f3 == F3_SB || f3 == F3_SW)) begin
                ea = a + simm;
                if (f3 == F3_SW) begin
                    store_word(word_of(ea), b);
                end else begin
                    w = load_word(word_of(ea));
                    w[ea[1:0]*8 +: 8] = b[7:0];
                    store_word(word_of(ea), w);
                end
            end else if (opc == OPC_LUI) begin
                write_reg(rd, {ins[31:12], 12'd0});
            end else if (opc == OPC_OP && f3 == F3_ADD) begin
                write_reg(rd, a + b);
            end else begin
                faulted = 1'b1;
                halted = 1'b1;
                return;
            end
            pc = nxt;
        endfunction

        function void record_request(logic [1:0] op, logic [WA_W-1:0] wa,
                                     logic [XLEN-1:0] wd);
            core_status_t st;
            int           idx;
            idx = int'(wa) % MEM_WORDS_DEF;
            st.rdata = '0;
            case (op)
                OP_WRITE_WORD: store_word(idx, wd);
                OP_EXECUTE: if (!halted) advance_core();
                OP_READ_WORD: st.rdata = load_word(idx);
                default: ;
            endcase
            st.pc = pc;
            st.halted = halted;
            st.fault = faulted;
            st.ret_value = regs[REG_RET];
            expected_status.push_back(st);
        endfunction

        function void check_response(logic [XLEN-1:0] pc_act, logic [XLEN-1:0] rdata_act,
                                     logic halted_act, logic fault_act,
                                     logic [XLEN-1:0] ret_act);
            core_status_t st;
            if (expected_status.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            st = expected_status.pop_front();
            if (pc_act !== st.pc) begin
                $error("program_counter: expected %h, actual %h", st.pc, pc_act);
                errors++;
            end
            if (rdata_act !== st.rdata) begin
                $error("read_data: expected %h, actual %h", st.rdata, rdata_act);
                errors++;
            end
            if (halted_act !== st.halted) begin
                $error("halted: expected %b, actual %b", st.halted, halted_act);
                errors++;
            end
            if (fault_act !== st.fault) begin
                $error("fault: expected %b, actual %b", st.fault, fault_act);
                errors++;
            end
            if (ret_act !== st.ret_value) begin
                $error("result_register: expected %h, actual %h", st.ret_value, ret_act);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    logic [1:0]      i_operation = '0;
    logic [WA_W-1:0] i_word_address = '0;
    logic [XLEN-1:0] i_write_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [XLEN-1:0] o_program_counter;
    logic [XLEN-1:0] o_read_data;
    logic            o_halted;
    logic            o_fault;
    logic [XLEN-1:0] o_result_register;

    core_scoreboard sb;
    int             items_sent = 0;
    logic           idling_on = 1'b1;
    logic           hold_req = 1'b0;
    logic           hold_done = 1'b0;

    rv32_subset_multicycle_core u_dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [6:0] opc);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [4:0]  rd, rs1, rs2;
        logic [11:0] imm;
        rd = ($urandom_range(0, 3) == 0) ? REG_RET : 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        imm = 12'($urandom);
        case ($urandom_range(0, 7))
            0: return enc_r(7'($urandom), rs2, rs1, F3_ADD, rd, OPC_OP);
            1: return enc_i(imm, rs1, F3_ADD, rd, OPC_OPIMM);
            2: return enc_u(20'($urandom), rd, OPC_LUI);
            3: return enc_i(imm, rs1, F3_LW, rd, OPC_LOAD);
            4: return enc_i(imm, rs1, F3_LBU, rd, OPC_LOAD);
            5: return enc_s(imm, rs2, rs1, F3_SW, OPC_STORE);
            6: return enc_s(imm, rs2, rs1, F3_SB, OPC_STORE);
            default: return enc_i(imm, rs1, F3_JALR, rd, OPC_JALR);
        endcase
    endfunction

    function automatic logic [31:0] fault_instr();
        logic [31:0] ins;
        logic [6:0]  opc;
        logic [2:0]  f3;
        ins = $urandom;
        f3 = ins[14:12];
        case ($urandom_range(0, 5))
            0: begin
                do opc = 7'($urandom);
                while (opc == OPC_HALT || opc == OPC_JALR || opc == OPC_LOAD ||
                       opc == OPC_OPIMM || opc == OPC_STORE || opc == OPC_LUI ||
                       opc == OPC_OP);
            end
            1: begin
                opc = OPC_JALR;
                f3 = 3'($urandom_range(1, 7));
            end
            2: begin
                opc = OPC_LOAD;
                do f3 = 3'($urandom);
                while (f3 == F3_LW || f3 == F3_LBU);
            end
            3: begin
                opc = OPC_OPIMM;
                f3 = 3'($urandom_range(1, 7));
            end
            4: begin
                opc = OPC_STORE;
                do f3 = 3'($urandom);
                while (f3 == F3_SB || f3 == F3_SW);
            end
            default: begin
                opc = OPC_OP;
                f3 = 3'($urandom_range(1, 7));
            end
        endcase
        ins[6:0] = opc;
        ins[14:12] = f3;
        return ins;
    endfunction

    task automatic send(input core_op_e op, input logic [WA_W-1:0] wa,
                        input logic [XLEN-1:0] wd);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_word_address <= wa;
        i_write_data <= wd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.record_request(op, wa, wd);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic ensure_word(input int idx);
        if (!sb.mem_words.exists(idx)) send(OP_WRITE_WORD, WA_W'(idx), $urandom);
    endtask

    task automatic run_instr(input logic [31:0] ins);
        logic [31:0] ea;
        if (ins[6:0] == OPC_STORE)
            ea = sb.regs[ins[19:15]] + {{20{ins[31]}}, ins[31:25], ins[11:7]};
        else
            ea = sb.regs[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
        // Loads and byte stores read the target word, so it must hold a known value.
        if (ins[6:0] == OPC_LOAD || (ins[6:0] == OPC_STORE && ins[14:12] == F3_SB))
            ensure_word(sb.word_of(ea));
        send(OP_WRITE_WORD, WA_W'(sb.word_of(sb.pc)), ins);
        send(OP_EXECUTE, WA_W'($urandom), $urandom);
    endtask

    task automatic read_known_word();
        send(OP_READ_WORD, WA_W'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]),
             $urandom);
    endtask

    initial begin
        int r;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(OP_UNUSED, WA_W'($urandom), $urandom);
        send(OP_WRITE_WORD, 16'hFFFF, 32'hFFFF_FFFF);
        send(OP_READ_WORD, 16'hFFFF, $urandom);
        run_instr(enc_u(20'hFFFFF, REG_RET, OPC_LUI));
        run_instr(enc_i(12'h7FF, REG_RET, F3_ADD, REG_RET, OPC_OPIMM));
        run_instr(enc_i(12'h800, REG_RET, F3_ADD, REG_RET, OPC_OPIMM));
        run_instr(enc_r(7'h7F, REG_RET, REG_RET, F3_ADD, REG_RET, OPC_OP));
        run_instr(enc_u(20'hABCDE, REG_ZERO, OPC_LUI));
        run_instr(enc_u(20'h12345, 5'd5, OPC_LUI));
        run_instr(enc_s(12'hFFC, 5'd5, REG_ZERO, F3_SW, OPC_STORE));
        run_instr(enc_i(12'hFFC, REG_ZERO, F3_LW, REG_RET, OPC_LOAD));
        run_instr(enc_i(12'hFFE, REG_ZERO, F3_LBU, REG_RET, OPC_LOAD));
        run_instr(enc_s(12'hFFF, REG_RET, REG_ZERO, F3_SB, OPC_STORE));
        send(OP_READ_WORD, 16'hFFFF, $urandom);
        run_instr(enc_i(12'd7, 5'd5, F3_JALR, REG_RET, OPC_JALR));

        hold_req = 1'b1;
        while (items_sent < ITEMS_TARGET) begin
            if (items_sent > ITEMS_TARGET - CALM_ITEMS) idling_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 62) run_instr(rand_instr());
            else if (r < 77) send(OP_WRITE_WORD, WA_W'($urandom), $urandom);
            else if (r < 92) read_known_word();
            else send(OP_UNUSED, WA_W'($urandom), $urandom);
        end

        if ($urandom_range(0, 1) == 0) run_instr({25'($urandom), OPC_HALT});
        else run_instr(fault_instr());
        repeat (4) begin
            send(OP_EXECUTE, WA_W'($urandom), $urandom);
            send(OP_WRITE_WORD, WA_W'($urandom), $urandom);
            read_known_word();
            send(OP_UNUSED, WA_W'($urandom), $urandom);
        end
        i_in_valid <= 1'b0;

        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_response(o_program_counter, o_read_data, o_halted, o_fault,
                              o_result_register);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
